FILE: sv/anrq_pkg.sv
// ----------------------------------------------------------------------------
// anrq_pkg
// Shared types, codes and constants of the retransmit queue unit.
// ----------------------------------------------------------------------------
package anrq_pkg;

   localparam int QUEUE_SLOTS_DEF = 8;
   localparam int MSG_BYTES_DEF   = 40;
   localparam int RX_BUF_SIZE_DEF = 64;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_RX    = 2'd1;
   localparam logic [1:0] MODE_SEND  = 2'd2;
   localparam logic [1:0] MODE_CHECK = 2'd3;

   localparam logic [1:0] ST_ACKED   = 2'd0;
   localparam logic [1:0] ST_DROPPED = 2'd1;
   localparam logic [1:0] ST_PENDING = 2'd2;
   localparam logic [1:0] ST_NONE    = 2'd3;

   localparam logic [2:0] REG_ACK     = 3'd0;
   localparam logic [2:0] REG_NAK     = 3'd1;
   localparam logic [2:0] REG_TIMEOUT = 3'd2;
   localparam logic [2:0] REG_RETRY   = 3'd3;
   localparam logic [2:0] REG_SILENCE = 3'd4;

   localparam logic [7:0] ACK_RST     = 8'd6;
   localparam logic [7:0] NAK_RST     = 8'd21;
   localparam logic [7:0] TIMEOUT_RST = 8'd50;
   localparam logic [3:0] RETRY_RST   = 4'd4;
   localparam logic [3:0] SILENCE_RST = 4'd5;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_DECIDE,
      FSM_SEND,
      FSM_STATUS
   } fsm_state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;    // take the new item
      logic apply;      // commit the item's state update
      logic rd_first;   // read first byte of head message
      logic rd_next;    // emit byte, read next
      logic emit_stat;  // emit status item
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic do_send;    // the item sends the head message
      logic last_tx;    // byte being emitted is the last
   } ctrl_stat_type;

endpackage

FILE: sv/anrq_ctrl.sv
// ----------------------------------------------------------------------------
// anrq_ctrl
// Sequencer: decide, stream the message bytes, then the status item.
// ----------------------------------------------------------------------------
module anrq_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   output anrq_pkg::ctrl_cmd_type   cmd,
   input  anrq_pkg::ctrl_stat_type  stat
);

   anrq_pkg::fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= anrq_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         anrq_pkg::FSM_IDLE: begin
            if (start) state_in = anrq_pkg::FSM_DECIDE;
         end
         anrq_pkg::FSM_DECIDE: begin
            state_in = stat.do_send ? anrq_pkg::FSM_SEND : anrq_pkg::FSM_STATUS;
         end
         anrq_pkg::FSM_SEND: begin
            if (stat.last_tx) state_in = anrq_pkg::FSM_STATUS;
         end
         anrq_pkg::FSM_STATUS: state_in = anrq_pkg::FSM_IDLE;
         default: state_in = anrq_pkg::FSM_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         anrq_pkg::FSM_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         anrq_pkg::FSM_DECIDE: begin
            cmd.apply    = 1'b1;
            cmd.rd_first = stat.do_send;
         end
         anrq_pkg::FSM_SEND:   cmd.rd_next   = 1'b1;
         anrq_pkg::FSM_STATUS: cmd.emit_stat = 1'b1;
         default: busy = 1'b1;
      endcase
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.apply, cmd.rd_next, cmd.emit_stat}) <= 1)
      else $error("more than one phase command");
   a_capture_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == anrq_pkg::FSM_DECIDE)
      else $error("capture did not enter decide");
   a_send_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == anrq_pkg::FSM_SEND && stat.last_tx) |=>
      state_ff == anrq_pkg::FSM_STATUS)
      else $error("send did not end in status");

endmodule

FILE: sv/anrq_dp.sv
// ----------------------------------------------------------------------------
// anrq_dp
// Datapath: queue state, message memory, counters and result drive.
// ----------------------------------------------------------------------------
module anrq_dp #(
   parameter int QUEUE_SLOTS = anrq_pkg::QUEUE_SLOTS_DEF,
   parameter int MSG_BYTES   = anrq_pkg::MSG_BYTES_DEF,
   parameter int RX_BUF_SIZE = anrq_pkg::RX_BUF_SIZE_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  anrq_pkg::ctrl_cmd_type   cmd,
   output anrq_pkg::ctrl_stat_type  stat,
   input  logic [1:0]               req_mode,
   input  logic [7:0]               req_data_byte,
   input  logic                     req_last_byte,
   input  logic                     csr_valid,
   input  logic [2:0]               csr_index,
   input  logic [7:0]               csr_data,
   output logic                     rsp_valid,
   output logic                     rsp_out_kind,
   output logic [7:0]               rsp_tx_byte,
   output logic                     rsp_last_result,
   output logic [1:0]               rsp_check_status,
   output logic                     rsp_link_enabled,
   output logic                     rsp_waiting_reply,
   output logic [7:0]               rsp_overflow_total,
   output logic [31:0]              rsp_ack_total,
   output logic [31:0]              rsp_nak_total,
   output logic [31:0]              rsp_other_total
);

   localparam int SW    = $clog2(QUEUE_SLOTS);
   localparam int LW    = $clog2(MSG_BYTES + 1);
   localparam int RW    = $clog2(RX_BUF_SIZE);
   localparam int DEPTH = QUEUE_SLOTS * MSG_BYTES;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [LW-1:0] MSG_MAX  = LW'(MSG_BYTES);
   localparam logic [SW-1:0] SLOT_TOP = SW'(QUEUE_SLOTS - 1);
   localparam logic [RW:0]   RX_TOP   = (RW+1)'(RX_BUF_SIZE);

   logic [7:0] mem [DEPTH];
   logic [LW-1:0] slot_len_ff [QUEUE_SLOTS];
   logic [QUEUE_SLOTS-1:0] slot_valid_ff;

   logic [7:0] ack_code_ff, nak_code_ff, timeout_ticks_ff;
   logic [3:0] retry_limit_ff, silence_limit_ff;

   logic [1:0] mode_ff;
   logic [7:0] data_ff;
   logic       last_ff;

   logic [SW-1:0] wslot_ff, rslot_ff;
   logic [LW-1:0] load_idx_ff, tx_idx_ff, tx_len_ff;
   logic          discard_ff;
   logic [RW-1:0] rx_count_ff;
   logic [7:0]    rx_first_ff;
   logic          awaiting_ff, link_ff;
   logic [7:0]    tleft_ff;
   logic [3:0]    bad_ff, sil_ff, silmsg_ff;
   logic [31:0]   ackc_ff, nakc_ff, othc_ff;
   logic [7:0]    ovf_ff;
   logic [1:0]    status_ff;
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] rd_addr;

   // Decision for the captured item, from registered state only.
   logic       wfull, send_now, free_now, disable_now, tick_down;
   logic [1:0] status_in;
   logic [3:0] bad_inc, sil_inc;
   logic       is_ack, is_nak, one_reply;

   always_comb begin
      bad_inc     = (bad_ff == 4'd15) ? 4'd15 : bad_ff + 4'd1;
      sil_inc     = (sil_ff == 4'd15) ? 4'd15 : sil_ff + 4'd1;
      one_reply   = (rx_count_ff == RW'(1));
      is_ack      = (rx_first_ff == ack_code_ff);
      is_nak      = (rx_first_ff == nak_code_ff);
      wfull       = slot_valid_ff[wslot_ff];
      send_now    = 1'b0;
      free_now    = 1'b0;
      disable_now = 1'b0;
      tick_down   = 1'b0;
      status_in   = anrq_pkg::ST_NONE;
      if (mode_ff == anrq_pkg::MODE_SEND) begin
         send_now = link_ff && slot_valid_ff[rslot_ff];
      end else if (mode_ff == anrq_pkg::MODE_CHECK && awaiting_ff) begin
         status_in = anrq_pkg::ST_PENDING;
         if (one_reply) begin
            if (is_ack) begin
               free_now  = 1'b1;
               status_in = anrq_pkg::ST_ACKED;
            end else if (bad_inc < retry_limit_ff) begin
               send_now = slot_valid_ff[rslot_ff];
            end else begin
               free_now  = 1'b1;
               status_in = anrq_pkg::ST_DROPPED;
            end
         end else if (silmsg_ff > silence_limit_ff) begin
            disable_now = 1'b1;
         end else if (tleft_ff != 8'd0) begin
            tick_down = 1'b1;
         end else if (sil_inc < retry_limit_ff) begin
            send_now = slot_valid_ff[rslot_ff];
         end else begin
            free_now  = 1'b1;
            status_in = anrq_pkg::ST_DROPPED;
         end
      end
   end

   assign stat.do_send = send_now;
   assign stat.last_tx = (tx_idx_ff == tx_len_ff);

   assign rd_addr = cmd.rd_first ? AW'(rslot_ff * MSG_BYTES)
                                 : AW'(rslot_ff * MSG_BYTES + tx_idx_ff);

   // Message memory: one write port for loads, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.apply && mode_ff == anrq_pkg::MODE_LOAD && !discard_ff &&
          !(load_idx_ff == '0 && wfull) && load_idx_ff < MSG_MAX) begin
         mem[AW'(wslot_ff * MSG_BYTES + load_idx_ff)] <= data_ff;
      end
      if (cmd.rd_first || (cmd.rd_next && !stat.last_tx)) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         data_ff <= req_data_byte;
         last_ff <= req_last_byte;
      end
      if (cmd.apply) status_ff <= status_in;
      if (cmd.apply && mode_ff == anrq_pkg::MODE_LOAD && !discard_ff &&
          !(load_idx_ff == '0 && wfull) && last_ff) begin
         slot_len_ff[wslot_ff] <= (load_idx_ff < MSG_MAX) ? load_idx_ff + LW'(1)
                                                          : load_idx_ff;
      end
      if (cmd.rd_first) begin
         tx_len_ff <= slot_len_ff[rslot_ff];
         tx_idx_ff <= LW'(1);
      end else if (cmd.rd_next) begin
         tx_idx_ff <= tx_idx_ff + LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_code_ff      <= anrq_pkg::ACK_RST;
         nak_code_ff      <= anrq_pkg::NAK_RST;
         timeout_ticks_ff <= anrq_pkg::TIMEOUT_RST;
         retry_limit_ff   <= anrq_pkg::RETRY_RST;
         silence_limit_ff <= anrq_pkg::SILENCE_RST;
      end else if (csr_valid) begin
         case (csr_index)
            anrq_pkg::REG_ACK:     ack_code_ff      <= csr_data;
            anrq_pkg::REG_NAK:     nak_code_ff      <= csr_data;
            anrq_pkg::REG_TIMEOUT: timeout_ticks_ff <= csr_data;
            anrq_pkg::REG_RETRY:   retry_limit_ff   <= csr_data[3:0];
            anrq_pkg::REG_SILENCE: silence_limit_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         wslot_ff      <= '0;
         rslot_ff      <= '0;
         load_idx_ff   <= '0;
         discard_ff    <= 1'b0;
         rx_count_ff   <= '0;
         rx_first_ff   <= '0;
         awaiting_ff   <= 1'b0;
         link_ff       <= 1'b1;
         tleft_ff      <= '0;
         bad_ff        <= '0;
         sil_ff        <= '0;
         silmsg_ff     <= '0;
         ackc_ff       <= '0;
         nakc_ff       <= '0;
         othc_ff       <= '0;
         ovf_ff        <= '0;
      end else if (cmd.apply) begin
         case (mode_ff)
            anrq_pkg::MODE_LOAD: begin
               if (discard_ff || (load_idx_ff == '0 && wfull)) begin
                  if (!discard_ff) ovf_ff <= ovf_ff + 8'd1;
                  discard_ff <= !last_ff;
               end else if (last_ff) begin
                  slot_valid_ff[wslot_ff] <= 1'b1;
                  wslot_ff    <= (wslot_ff == SLOT_TOP) ? '0 : wslot_ff + SW'(1);
                  load_idx_ff <= '0;
               end else if (load_idx_ff < MSG_MAX) begin
                  load_idx_ff <= load_idx_ff + LW'(1);
               end
            end
            anrq_pkg::MODE_RX: begin
               if (rx_count_ff == '0) rx_first_ff <= data_ff;
               rx_count_ff <= (({1'b0, rx_count_ff} + (RW+1)'(1)) >= RX_TOP)
                  ? '0 : rx_count_ff + RW'(1);
            end
            default: begin
               if (mode_ff == anrq_pkg::MODE_CHECK && awaiting_ff) begin
                  if (one_reply) begin
                     silmsg_ff <= '0;
                     if (is_ack) ackc_ff <= ackc_ff + 32'd1;
                     else if (is_nak) nakc_ff <= nakc_ff + 32'd1;
                     else othc_ff <= othc_ff + 32'd1;
                     if (!is_ack) bad_ff <= bad_inc;
                  end else if (!disable_now && !tick_down) begin
                     sil_ff <= sil_inc;
                     if (free_now) silmsg_ff <= (silmsg_ff == 4'd15) ? 4'd15
                                                                     : silmsg_ff + 4'd1;
                  end
               end
               if (disable_now) begin
                  link_ff     <= 1'b0;
                  awaiting_ff <= 1'b0;
               end
               if (tick_down) tleft_ff <= tleft_ff - 8'd1;
               if (send_now) begin
                  rx_count_ff <= '0;
                  rx_first_ff <= '0;
                  awaiting_ff <= 1'b1;
                  tleft_ff    <= timeout_ticks_ff;
               end
               if (free_now) begin
                  slot_valid_ff[rslot_ff] <= 1'b0;
                  rslot_ff    <= (rslot_ff == SLOT_TOP) ? '0 : rslot_ff + SW'(1);
                  bad_ff      <= '0;
                  sil_ff      <= '0;
                  awaiting_ff <= 1'b0;
               end
            end
         endcase
      end
   end

   // Zero-length messages are sent as status only: len 0 makes last_tx
   // never fire before the first byte, so guard via tx_len.
   logic tx_phase_ff;
   always_ff @(posedge clock) begin
      if (reset) tx_phase_ff <= 1'b0;
      else tx_phase_ff <= cmd.rd_first || (cmd.rd_next && !stat.last_tx);
   end

   assign rsp_valid          = (tx_phase_ff && tx_len_ff != '0) || cmd.emit_stat;
   assign rsp_out_kind       = cmd.emit_stat;
   assign rsp_tx_byte        = cmd.emit_stat ? 8'd0 : rd_data_ff;
   assign rsp_last_result    = cmd.emit_stat;
   assign rsp_check_status   = cmd.emit_stat ? status_ff : anrq_pkg::ST_NONE;
   assign rsp_link_enabled   = link_ff;
   assign rsp_waiting_reply  = awaiting_ff;
   assign rsp_overflow_total = ovf_ff;
   assign rsp_ack_total      = ackc_ff;
   assign rsp_nak_total      = nakc_ff;
   assign rsp_other_total    = othc_ff;

   a_free_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.apply && free_now) |=> !awaiting_ff)
      else $error("freed slot still awaiting");
   a_send_arms: assert property (@(posedge clock) disable iff (reset)
      (cmd.apply && send_now) |=> awaiting_ff)
      else $error("send did not arm wait");
   a_link_off: assert property (@(posedge clock) disable iff (reset)
      !link_ff |=> !link_ff)
      else $error("link came back on");

endmodule

FILE: sv/ack_nak_retransmit_queue_unit.sv
// ----------------------------------------------------------------------------
// ack_nak_retransmit_queue_unit
// Stop-and-wait sender over a ring of message slots.
// ----------------------------------------------------------------------------
// Use: raise start with req_mode/req_data_byte/req_last_byte while busy is
// low; the item is taken on that edge and busy rises until it is done.
// Every item yields zero or more message byte items (rsp_out_kind 0)
// then one status item (rsp_out_kind 1, rsp_last_result 1), each shown for
// exactly one cycle with rsp_valid high. The receiver cannot stall.
// An item without transmission passes through capture, decide and status;
// a send streams its message between decide and status, one byte per cycle
// through the registered read port of the message memory.
// Configuration: write csr_index/csr_data with csr_valid; csr_ready is
// always high. Write only while busy is low.
// Reset: queue empty, link enabled, counters zero, registers to defaults.
// The message memory is not cleared; unwritten bytes are never sent.
module ack_nak_retransmit_queue_unit #(
   parameter int QUEUE_SLOTS = anrq_pkg::QUEUE_SLOTS_DEF,
   parameter int MSG_BYTES   = anrq_pkg::MSG_BYTES_DEF,
   parameter int RX_BUF_SIZE = anrq_pkg::RX_BUF_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data,
   output logic        rsp_valid,
   output logic        rsp_out_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last_result,
   output logic [1:0]  rsp_check_status,
   output logic        rsp_link_enabled,
   output logic        rsp_waiting_reply,
   output logic [7:0]  rsp_overflow_total,
   output logic [31:0] rsp_ack_total,
   output logic [31:0] rsp_nak_total,
   output logic [31:0] rsp_other_total
);

   anrq_pkg::ctrl_cmd_type  cmd;
   anrq_pkg::ctrl_stat_type stat;

   assign csr_ready = 1'b1;

   // Sequence each item through decide, byte stream and status.
   anrq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   // Hold queue state and drive the result ports.
   anrq_dp #(
      .QUEUE_SLOTS (QUEUE_SLOTS),
      .MSG_BYTES   (MSG_BYTES),
      .RX_BUF_SIZE (RX_BUF_SIZE)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_mode           (req_mode),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_valid          (rsp_valid),
      .rsp_out_kind       (rsp_out_kind),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_last_result    (rsp_last_result),
      .rsp_check_status   (rsp_check_status),
      .rsp_link_enabled   (rsp_link_enabled),
      .rsp_waiting_reply  (rsp_waiting_reply),
      .rsp_overflow_total (rsp_overflow_total),
      .rsp_ack_total      (rsp_ack_total),
      .rsp_nak_total      (rsp_nak_total),
      .rsp_other_total    (rsp_other_total)
   );

endmodule

FILE: tb/ack_nak_retransmit_queue_unit_tb.sv
// ----------------------------------------------------------------------------
// ack_nak_retransmit_queue_unit_tb
// Self-checking bench for the stop-and-wait retransmit queue. A clocked
// driver feeds items and register writes from a queue. A built-in predictor
// computes the byte and status results of every accepted item. A monitor
// compares each result strobe with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ack_nak_retransmit_queue_unit_tb;

   localparam int SLOTS     = anrq_pkg::QUEUE_SLOTS_DEF;
   localparam int MSG_MAX   = anrq_pkg::MSG_BYTES_DEF;
   localparam int RX_WRAP   = anrq_pkg::RX_BUF_SIZE_DEF;
   localparam int IDLE_PCT  = 15;
   localparam int SETTLE    = 50;
   localparam int CYCLE_CAP = 300000;

   typedef enum logic [2:0] {
      E_ITEM, E_CSR, E_DRAIN, E_CALM, E_NOISY
   } entry_kind_type;

   typedef struct {
      entry_kind_type kind;
      logic [1:0]     mode;
      logic [7:0]     data;
      logic           last;
      logic [2:0]     index;
      logic [7:0]     value;
   } entry_type;

   typedef struct {
      logic        out_kind;
      logic [7:0]  tx_byte;
      logic        last_result;
      logic [1:0]  check_status;
      logic        link_enabled;
      logic        waiting_reply;
      logic [7:0]  overflow_total;
      logic [31:0] ack_total;
      logic [31:0] nak_total;
      logic [31:0] other_total;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_mode = anrq_pkg::MODE_LOAD;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = anrq_pkg::REG_ACK;
   logic [7:0]  csr_data = 8'd0;
   logic        rsp_valid;
   logic        rsp_out_kind;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_last_result;
   logic [1:0]  rsp_check_status;
   logic        rsp_link_enabled;
   logic        rsp_waiting_reply;
   logic [7:0]  rsp_overflow_total;
   logic [31:0] rsp_ack_total;
   logic [31:0] rsp_nak_total;
   logic [31:0] rsp_other_total;

   ack_nak_retransmit_queue_unit dut (.*);

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor state: register copies and queue state of the block
   // ---------------------------------------------------------------------
   logic [7:0]  cfg_ack, cfg_nak, cfg_timeout;
   logic [3:0]  cfg_retry, cfg_silence;

   logic [7:0]  msg_mem [SLOTS*MSG_MAX];
   int          slot_len [SLOTS];
   bit          slot_full [SLOTS];
   int          wr_slot, rd_slot, load_pos;
   bit          load_skip;
   int          rx_cnt;
   logic [7:0]  rx_head;
   bit          waiting;
   int          ticks_left, bad_tries, quiet_tries, quiet_msgs;
   bit          link_up;
   logic [31:0] acks, naks, others;
   logic [7:0]  overflows;

   logic [7:0]  sent_bytes [$];
   result_type  expected_q [$];
   entry_type   pending_q [$];
   int          fails = 0;

   initial begin
      cfg_ack = anrq_pkg::ACK_RST; cfg_nak = anrq_pkg::NAK_RST;
      cfg_timeout = anrq_pkg::TIMEOUT_RST;
      cfg_retry = anrq_pkg::RETRY_RST; cfg_silence = anrq_pkg::SILENCE_RST;
      foreach (slot_full[i]) begin
         slot_full[i] = 0;
         slot_len[i] = 0;
      end
      wr_slot = 0; rd_slot = 0; load_pos = 0; load_skip = 0;
      rx_cnt = 0; rx_head = 0; waiting = 0; ticks_left = 0;
      bad_tries = 0; quiet_tries = 0; quiet_msgs = 0; link_up = 1;
      acks = 0; naks = 0; others = 0; overflows = 0;
   end

   function automatic int sat15(int v);
      return (v < 15) ? v + 1 : 15;
   endfunction

   // transmit the head message and arm the reply wait
   function automatic void send_head_msg();
      int len;
      if (!slot_full[rd_slot]) return;
      rx_cnt = 0;
      rx_head = 0;
      waiting = 1;
      ticks_left = int'(cfg_timeout);
      len = (slot_len[rd_slot] > MSG_MAX) ? MSG_MAX : slot_len[rd_slot];
      for (int i = 0; i < len; i++) sent_bytes.push_back(msg_mem[rd_slot*MSG_MAX + i]);
   endfunction

   function automatic void release_head();
      slot_full[rd_slot] = 0;
      slot_len[rd_slot] = 0;
      rd_slot = (rd_slot + 1) % SLOTS;
      bad_tries = 0;
      quiet_tries = 0;
      waiting = 0;
   endfunction

   // work out the results of one accepted item and queue them
   function automatic void predict_item(logic [1:0] mode, logic [7:0] data, logic last);
      logic [1:0] status;
      result_type r;
      status = anrq_pkg::ST_NONE;
      sent_bytes.delete();
      case (mode)
         anrq_pkg::MODE_LOAD: begin
            if (load_pos == 0 && !load_skip && slot_full[wr_slot]) begin
               overflows = overflows + 8'd1;
               load_skip = 1;
            end
            if (load_skip) begin
               if (last) load_skip = 0;
            end else begin
               if (load_pos < MSG_MAX) begin
                  msg_mem[wr_slot*MSG_MAX + load_pos] = data;
                  load_pos++;
               end
               if (last) begin
                  slot_len[wr_slot] = load_pos;
                  slot_full[wr_slot] = 1;
                  wr_slot = (wr_slot + 1) % SLOTS;
                  load_pos = 0;
               end
            end
         end
         anrq_pkg::MODE_RX: begin
            if (rx_cnt == 0) rx_head = data;
            rx_cnt++;
            if (rx_cnt >= RX_WRAP) rx_cnt = 0;
         end
         anrq_pkg::MODE_SEND: begin
            if (link_up) send_head_msg();
         end
         default: begin
            if (waiting) begin
               status = anrq_pkg::ST_PENDING;
               if (rx_cnt == 1) begin
                  quiet_msgs = 0;
                  if (rx_head == cfg_ack) begin
                     acks++;
                     release_head();
                     status = anrq_pkg::ST_ACKED;
                  end else begin
                     if (rx_head == cfg_nak) naks++;
                     else others++;
                     bad_tries = sat15(bad_tries);
                     if (bad_tries < int'(cfg_retry)) send_head_msg();
                     else begin
                        release_head();
                        status = anrq_pkg::ST_DROPPED;
                     end
                  end
               end else if (quiet_msgs > int'(cfg_silence)) begin
                  link_up = 0;
                  waiting = 0;
               end else if (ticks_left > 0) begin
                  ticks_left--;
               end else begin
                  quiet_tries = sat15(quiet_tries);
                  if (quiet_tries < int'(cfg_retry)) send_head_msg();
                  else begin
                     quiet_msgs = sat15(quiet_msgs);
                     release_head();
                     status = anrq_pkg::ST_DROPPED;
                  end
               end
            end
         end
      endcase
      r.link_enabled = link_up;
      r.waiting_reply = waiting;
      r.overflow_total = overflows;
      r.ack_total = acks;
      r.nak_total = naks;
      r.other_total = others;
      r.out_kind = 0;
      r.last_result = 0;
      r.check_status = anrq_pkg::ST_NONE;
      foreach (sent_bytes[i]) begin
         r.tx_byte = sent_bytes[i];
         expected_q.push_back(r);
      end
      r.out_kind = 1;
      r.tx_byte = 8'd0;
      r.last_result = 1;
      r.check_status = status;
      expected_q.push_back(r);
   endfunction

   function automatic void write_reg(logic [2:0] index, logic [7:0] value);
      case (index)
         anrq_pkg::REG_ACK:     cfg_ack = value;
         anrq_pkg::REG_NAK:     cfg_nak = value;
         anrq_pkg::REG_TIMEOUT: cfg_timeout = value;
         anrq_pkg::REG_RETRY:   cfg_retry = value[3:0];
         anrq_pkg::REG_SILENCE: cfg_silence = value[3:0];
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Driver: present queued entries, hold start and csr_valid until taken
   // ---------------------------------------------------------------------
   bit noisy = 1;
   int drain_left = 0;

   always @(posedge clock) begin
      entry_type e;
      logic go_start, go_csr;
      if (reset) begin
         start <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         // commit what this edge took
         if (start && !busy) predict_item(req_mode, req_data_byte, req_last_byte);
         if (csr_valid && csr_ready) write_reg(csr_index, csr_data);
         if (!(start && busy) && !(csr_valid && !csr_ready)) begin
            go_start = 1'b0;
            go_csr = 1'b0;
            if (drain_left > 0) begin
               // hold off until every result is in, then let the block settle
               if (expected_q.size() == 0 && !busy) drain_left--;
            end else if (pending_q.size() > 0 &&
                         !(noisy && $urandom_range(99) < IDLE_PCT)) begin
               e = pending_q.pop_front();
               case (e.kind)
                  E_ITEM: begin
                     req_mode <= e.mode;
                     req_data_byte <= e.data;
                     req_last_byte <= e.last;
                     go_start = 1'b1;
                  end
                  E_CSR: begin
                     csr_index <= e.index;
                     csr_data <= e.value;
                     go_csr = 1'b1;
                  end
                  E_DRAIN: drain_left = SETTLE;
                  E_CALM:  noisy = 0;
                  default: noisy = 1;
               endcase
            end
            start <= go_start;
            csr_valid <= go_csr;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compare each strobed result with the oldest prediction
   // ---------------------------------------------------------------------
   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      result_type w;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0d byte %0h",
                     $time, rsp_out_kind, rsp_tx_byte);
            fails++;
         end else begin
            w = expected_q.pop_front();
            check_field("out_kind", 32'(w.out_kind), 32'(rsp_out_kind));
            check_field("tx_byte", 32'(w.tx_byte), 32'(rsp_tx_byte));
            check_field("last_result", 32'(w.last_result), 32'(rsp_last_result));
            check_field("check_status", 32'(w.check_status), 32'(rsp_check_status));
            check_field("link_enabled", 32'(w.link_enabled), 32'(rsp_link_enabled));
            check_field("waiting_reply", 32'(w.waiting_reply), 32'(rsp_waiting_reply));
            check_field("overflow_total", 32'(w.overflow_total),
                        32'(rsp_overflow_total));
            check_field("ack_total", w.ack_total, rsp_ack_total);
            check_field("nak_total", w.nak_total, rsp_nak_total);
            check_field("other_total", w.other_total, rsp_other_total);
         end
      end
   end

   // guard against a hung block
   int cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_CAP) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   int queued_items = 0;
   logic [7:0] plan_ack = anrq_pkg::ACK_RST, plan_nak = anrq_pkg::NAK_RST;

   task automatic add_item(logic [1:0] mode, logic [7:0] data, logic last);
      entry_type e;
      e.kind = E_ITEM; e.mode = mode; e.data = data; e.last = last;
      e.index = anrq_pkg::REG_ACK; e.value = 8'd0;
      pending_q.push_back(e);
      queued_items++;
   endtask

   task automatic add_ctrl(entry_kind_type kind, logic [2:0] index, logic [7:0] value);
      entry_type e;
      e.kind = kind; e.mode = anrq_pkg::MODE_LOAD; e.data = 8'd0; e.last = 1'b0;
      e.index = index; e.value = value;
      pending_q.push_back(e);
   endtask

   // drain, then write all five registers
   task automatic add_settings(logic [7:0] a, logic [7:0] n, logic [7:0] t,
                               logic [7:0] r, logic [7:0] s);
      add_ctrl(E_DRAIN, anrq_pkg::REG_ACK, 8'd0);
      add_ctrl(E_CSR, anrq_pkg::REG_ACK, a);
      add_ctrl(E_CSR, anrq_pkg::REG_NAK, n);
      add_ctrl(E_CSR, anrq_pkg::REG_TIMEOUT, t);
      add_ctrl(E_CSR, anrq_pkg::REG_RETRY, r);
      add_ctrl(E_CSR, anrq_pkg::REG_SILENCE, s);
      plan_ack = a;
      plan_nak = n;
   endtask

   task automatic add_message(int len);
      for (int i = 0; i < len; i++)
         add_item(anrq_pkg::MODE_LOAD, 8'($urandom_range(255)), i == len - 1);
   endtask

   // one random sequence: mostly well-formed exchanges, some noise
   task automatic add_sequence();
      int pick, n;
      logic [7:0] reply;
      pick = $urandom_range(99);
      if (pick < 35) begin
         n = $urandom_range(2, 1);
         for (int i = 0; i < n; i++)
            add_message(($urandom_range(19) == 0) ? $urandom_range(44, 41)
                                                   : $urandom_range(5, 1));
      end else if (pick < 85) begin
         add_item(anrq_pkg::MODE_SEND, 8'($urandom_range(255)), 1'($urandom_range(1)));
         n = $urandom_range(9);
         n = (n < 6) ? 1 : (n < 8 ? 0 : 2);
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(2))
               0: reply = plan_ack;
               1: reply = plan_nak;
               default: reply = 8'($urandom_range(255));
            endcase
            add_item(anrq_pkg::MODE_RX, reply, 1'($urandom_range(1)));
         end
         n = $urandom_range(4, 1);
         for (int i = 0; i < n; i++)
            add_item(anrq_pkg::MODE_CHECK, 8'($urandom_range(255)),
                     1'($urandom_range(1)));
      end else begin
         add_item(2'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
   endtask

   task automatic add_phase(int count);
      int stop;
      stop = queued_items + count;
      while (queued_items < stop) add_sequence();
   endtask

   initial begin
      // directed: idle tick and empty send, then ack, nak, silence, other reply
      add_item(anrq_pkg::MODE_CHECK, 8'h00, 1'b0);
      add_item(anrq_pkg::MODE_SEND, 8'hFF, 1'b1);
      add_item(anrq_pkg::MODE_LOAD, 8'h00, 1'b1);
      add_item(anrq_pkg::MODE_LOAD, 8'hFF, 1'b0);
      add_item(anrq_pkg::MODE_LOAD, 8'h5A, 1'b1);
      add_item(anrq_pkg::MODE_SEND, 8'h00, 1'b0);
      add_item(anrq_pkg::MODE_RX, anrq_pkg::ACK_RST, 1'b0);
      add_item(anrq_pkg::MODE_CHECK, 8'h00, 1'b0);
      add_item(anrq_pkg::MODE_SEND, 8'h00, 1'b0);
      add_item(anrq_pkg::MODE_RX, anrq_pkg::NAK_RST, 1'b0);
      add_item(anrq_pkg::MODE_CHECK, 8'hFF, 1'b1);
      add_item(anrq_pkg::MODE_RX, 8'hAB, 1'b1);
      add_item(anrq_pkg::MODE_RX, 8'h01, 1'b0);
      add_item(anrq_pkg::MODE_CHECK, 8'h00, 1'b0);
      add_item(anrq_pkg::MODE_SEND, 8'h00, 1'b0);
      add_item(anrq_pkg::MODE_RX, 8'h33, 1'b0);
      add_item(anrq_pkg::MODE_CHECK, 8'h00, 1'b0);
      add_item(anrq_pkg::MODE_CHECK, 8'h00, 1'b0);
      add_phase(18);

      add_settings(8'd0, 8'd255, 8'd0, 8'd1, 8'd15);
      add_phase(18);

      // stretch without any idling
      add_settings(8'd255, 8'd0, 8'd1, 8'd15, 8'd15);
      add_ctrl(E_CALM, anrq_pkg::REG_ACK, 8'd0);
      add_phase(22);
      add_ctrl(E_NOISY, anrq_pkg::REG_ACK, 8'd0);

      add_settings(8'($urandom_range(255)), 8'($urandom_range(255)), 8'd3,
                   8'($urandom_range(15, 1)), 8'd15);
      // fill the receive count past its wrap, then check
      add_item(anrq_pkg::MODE_SEND, 8'h00, 1'b0);
      for (int i = 0; i < RX_WRAP + 1; i++)
         add_item(anrq_pkg::MODE_RX, 8'($urandom_range(255)), 1'b0);
      add_item(anrq_pkg::MODE_CHECK, 8'h00, 1'b0);
      add_phase(14);

      add_settings(anrq_pkg::ACK_RST, anrq_pkg::NAK_RST, 8'd255, 8'd7, 8'd15);
      add_phase(10);

      // zero silence limit: a silent drop then shuts the link down
      add_settings(8'($urandom_range(255)), 8'($urandom_range(255)), 8'd0, 8'd2, 8'd0);
      add_phase(15);
      add_message(3);
      add_item(anrq_pkg::MODE_SEND, 8'h00, 1'b0);
      for (int i = 0; i < 8; i++) add_item(anrq_pkg::MODE_CHECK, 8'h00, 1'b0);
      add_phase(8);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      wait (pending_q.size() == 0 && !start && expected_q.size() == 0 && drain_left == 0);
      repeat (SETTLE) @(posedge clock);
      if (fails == 0 && expected_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/anrq_pkg.sv
sv/anrq_ctrl.sv
sv/anrq_dp.sv
sv/ack_nak_retransmit_queue_unit.sv
tb/ack_nak_retransmit_queue_unit_tb.sv
